>>> src/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // request kinds
  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_ERASE  = 2'd1,
    FUNC_DEFRAG = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // result codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  localparam int          ID_W         = 16;
  localparam logic [15:0] ID_MAX       = 16'hFFFF;
  localparam logic [15:0] ID_FREE      = 16'h0000;
  localparam logic [7:0]  MEM_SIZE_RST = 8'd128;

endpackage

`default_nettype wire

>>> src/ffba_ram.sv
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/first_fit_block_allocator.sv
`default_nettype none

// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// request  | in_valid, in_stall, in_func, in_amount  | in
// result   | out_valid, out_stall, out_status,       | out
//          | out_block_id                            |
// config   | cfg_wr_en, cfg_wr_data (memory_size)    | in
//
// one request at a time, the owner ram is walked one cell per cycle through
// its single read port (registered read) and single write port
// alloc: a scan for the first fitting free run, then one write per allocated cell
// erase: one scan that frees matching cells; defragment: compact, then clear
// after reset a clearing pass writes every cell free, in_stall high
// a result sits in an output register, so a stalled result does not hold back
// acceptance of the next request; that request's result waits for the register

module first_fit_block_allocator #(
  parameter int CELLS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_amount,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [1:0]  out_status,
  output logic      [15:0] out_block_id,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;  // cell address
  localparam int CW = $clog2(CELLS + 1);                // count up to CELLS
  localparam int UW = (CW > 8) ? CW : 8;                // size compare width

  // one-hot sequencer
  typedef enum logic [7:0] {
    S_INIT   = 8'b0000_0001,  // clearing pass after reset
    S_IDLE   = 8'b0000_0010,
    S_ASCAN  = 8'b0000_0100,  // alloc: look for a free run
    S_AFILL  = 8'b0000_1000,  // alloc: stamp the run with the new id
    S_ESCAN  = 8'b0001_0000,  // erase: free matching cells
    S_DSCAN  = 8'b0010_0000,  // defragment: copy owned cells forward
    S_DCLR   = 8'b0100_0000,  // defragment: free the tail
    S_RESULT = 8'b1000_0000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]    memory_size_r;
  logic [15:0]   last_id_r, last_id_nxt;
  logic [15:0]   amount_r, amount_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] addr_r, addr_nxt;     // next read address in a scan
  logic          pend_r, pend_nxt;     // read data of idx_r arrives this cycle
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] run_r, run_nxt;       // length of the current free run
  logic [CW-1:0] wptr_r, wptr_nxt;     // clear / compaction write pointer
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] end_r, end_nxt;
  logic          hit_r, hit_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [15:0]   res_id_r, res_id_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_id_r, out_id_nxt;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  logic          in_accept;
  logic          issue;
  logic          scan_done;
  logic [UW-1:0] ms_ext;
  logic [CW-1:0] used_now;
  logic [CW-1:0] run_inc;
  logic          cell_free;

  ffba_ram #(
    .WIDTH (ffba_pkg::ID_W),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_owner_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // cells in use: memory_size clipped to the built count
  assign ms_ext   = UW'(memory_size_r);
  assign used_now = (ms_ext > UW'(CELLS)) ? CW'(CELLS) : CW'(ms_ext);

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign issue     = (addr_r < used_r);
  assign scan_done = !issue && !pend_r;
  assign run_inc   = run_r + CW'(1);
  assign cell_free = (ram_rdata == ffba_pkg::ID_FREE);

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_block_id = out_id_r;

  always_comb begin
    state_nxt      = state_r;
    last_id_nxt    = last_id_r;
    amount_nxt     = amount_r;
    used_nxt       = used_r;
    addr_nxt       = addr_r;
    pend_nxt       = 1'b0;
    idx_nxt        = addr_r[AW-1:0];
    run_nxt        = run_r;
    wptr_nxt       = wptr_r;
    fill_nxt       = fill_r;
    end_nxt        = end_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    ram_we         = 1'b0;
    ram_waddr      = wptr_r[AW-1:0];
    ram_wdata      = ffba_pkg::ID_FREE;

    // output register drains independently of the sequencer
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;

    case (state_r)
      S_INIT: begin
        ram_we   = 1'b1;
        wptr_nxt = wptr_r + CW'(1);
        if (wptr_r == CW'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          amount_nxt = in_amount;
          used_nxt   = used_now;
          addr_nxt   = '0;
          run_nxt    = '0;
          wptr_nxt   = '0;
          hit_nxt    = 1'b0;
          res_id_nxt = '0;
          case (in_func)
            ffba_pkg::FUNC_ALLOC: begin
              if (in_amount == 16'd0 || last_id_r == ffba_pkg::ID_MAX) begin
                res_status_nxt = ffba_pkg::ST_NULL;
                state_nxt      = S_RESULT;
              end else begin
                state_nxt = S_ASCAN;
              end
            end
            ffba_pkg::FUNC_ERASE: begin
              if (in_amount == ffba_pkg::ID_FREE) begin
                res_status_nxt = ffba_pkg::ST_ILLEGAL;
                state_nxt      = S_RESULT;
              end else begin
                state_nxt = S_ESCAN;
              end
            end
            ffba_pkg::FUNC_DEFRAG: begin
              state_nxt = S_DSCAN;
            end
            default: begin
              // unused request kind: nothing happens
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ASCAN: begin
        pend_nxt = issue;
        addr_nxt = addr_r + CW'(issue);
        if (pend_r) begin
          if (!cell_free) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_inc;
            if (32'(run_inc) == 32'(amount_r)) begin
              // first fitting run ends here
              last_id_nxt = last_id_r + 16'd1;
              end_nxt     = idx_r;
              fill_nxt    = idx_r - amount_r[AW-1:0] + AW'(1);
              pend_nxt    = 1'b0;
              state_nxt   = S_AFILL;
            end
          end
        end
        if (scan_done) begin
          res_status_nxt = ffba_pkg::ST_NULL;
          state_nxt      = S_RESULT;
        end
      end

      S_AFILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_r;
        ram_wdata = last_id_r;
        fill_nxt  = fill_r + AW'(1);
        if (fill_r == end_r) begin
          res_status_nxt = ffba_pkg::ST_OK;
          res_id_nxt     = last_id_r;
          state_nxt      = S_RESULT;
        end
      end

      S_ESCAN: begin
        pend_nxt = issue;
        addr_nxt = addr_r + CW'(issue);
        if (pend_r && ram_rdata == amount_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          hit_nxt   = 1'b1;
        end
        if (scan_done) begin
          if (hit_r) begin
            state_nxt = S_IDLE;
          end else begin
            res_status_nxt = ffba_pkg::ST_ILLEGAL;
            state_nxt      = S_RESULT;
          end
        end
      end

      S_DSCAN: begin
        pend_nxt = issue;
        addr_nxt = addr_r + CW'(issue);
        // write pointer never passes the read side, so unread cells stay intact
        if (pend_r && !cell_free) begin
          ram_we    = 1'b1;
          ram_waddr = wptr_r[AW-1:0];
          ram_wdata = ram_rdata;
          wptr_nxt  = wptr_r + CW'(1);
        end
        if (scan_done) begin
          state_nxt = S_DCLR;
        end
      end

      S_DCLR: begin
        if (wptr_r < used_r) begin
          ram_we   = 1'b1;
          wptr_nxt = wptr_r + CW'(1);
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      memory_size_r <= ffba_pkg::MEM_SIZE_RST;
      last_id_r     <= '0;
      wptr_r        <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_id_r   <= last_id_nxt;
      wptr_r      <= wptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        memory_size_r <= cfg_wr_data;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    amount_r     <= amount_nxt;
    used_r       <= used_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    run_r        <= run_nxt;
    fill_r       <= fill_nxt;
    end_r        <= end_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

`default_nettype wire
